/* design/tta_pkg.sv */
// Shared types and constants for the timestamp tick accumulator.
package tta_pkg;

    localparam int TTA_W     = 64;
    localparam int TTA_CNT_W = $clog2(TTA_W);

    localparam logic [TTA_CNT_W-1:0] TTA_CNT_LAST = TTA_CNT_W'(TTA_W - 1);

    typedef logic [TTA_W-1:0] t_word;

    localparam t_word TTA_ZERO = '0;
    localparam t_word TTA_ONE  = t_word'(1);

    // Status of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* design/tta_divider.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
module tta_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tta_pkg::t_word     i_dividend,
    input  tta_pkg::t_word     i_divisor,
    output tta_pkg::t_div_stat o_stat,
    output tta_pkg::t_word     o_quotient,
    output tta_pkg::t_word     o_remainder
);
    import tta_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [TTA_CNT_W-1:0] r_cnt;
    t_word                r_rem;
    t_word                r_quo;
    t_word                r_div;

    logic [TTA_W:0]   w_shift;
    logic [TTA_W+1:0] w_diff;
    logic             w_fit;

    // Shift in the next dividend bit and try the subtract.
    assign w_shift = {r_rem, r_quo[TTA_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_fit   = ~w_diff[TTA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == TTA_CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= TTA_ZERO;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[TTA_W-1:0] : w_shift[TTA_W-1:0];
            r_quo <= {r_quo[TTA_W-2:0], w_fit};
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

/* design/timestamp_tick_accumulator.sv */
// Top level: turns timer-event timestamps into whole system ticks.
//
// Input channel (i_in_valid / o_in_ready) carries one timestamp per request.
// Output channel (o_out_valid / i_out_ready) returns one result per request:
// ticks passed, system and source tick counts, and the leftover counts.
// The tick period is written through i_cfg_we / i_cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
//
// With a nonzero period one shared divider produces one quotient bit per
// cycle, then the request hands off to the done state and loads the output
// register; with a zero period it goes straight to the done state. The
// block takes one request at a time; o_in_ready is high only when no
// request is in work, so the next request is taken only once the last is
// loaded into the output register. A result held in the output register
// does not block the next request, but a finished result waits while the
// receiver stalls and the output register is still full.
//
// Synchronous reset clears the period, the stored timestamp (marked as not
// yet seen), the accumulator and both tick counters.
module timestamp_tick_accumulator (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  tta_pkg::t_word i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tta_pkg::t_word i_timestamp_now,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tta_pkg::t_word o_ticks_passed,
    output tta_pkg::t_word o_system_tick_count,
    output tta_pkg::t_word o_source_tick_count,
    output tta_pkg::t_word o_leftover_counts
);
    import tta_pkg::*;

    t_state r_state;
    t_state n_state;

    t_word r_period;
    t_word r_last;
    logic  r_seen;
    t_word r_acc;
    t_word r_sys;
    t_word r_src;
    logic  r_fallback;
    logic  r_out_valid;
    t_word r_passed;

    logic      w_accept;
    logic      w_div_start;
    logic      w_load;
    t_word     w_delta;
    t_word     w_sum;
    t_word     w_passed;
    t_div_stat w_div_stat;
    t_word     w_quo;
    t_word     w_rem;

    // First event spans exactly one period.
    assign w_delta  = r_seen ? (i_timestamp_now - r_last) : r_period;
    assign w_sum    = r_acc + w_delta;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_passed = r_fallback ? TTA_ONE : w_quo;

    tta_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_sum),
        .i_divisor   (r_period),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (r_period == TTA_ZERO) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_div_start = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                w_div_start = i_in_valid && (r_period != TTA_ZERO);
            end
            ST_DIV: begin
                o_in_ready = 1'b0;
            end
            ST_DONE: begin
                w_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_period    <= TTA_ZERO;
            r_last      <= TTA_ZERO;
            r_seen      <= 1'b0;
            r_acc       <= TTA_ZERO;
            r_sys       <= TTA_ZERO;
            r_src       <= TTA_ZERO;
            r_fallback  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (w_accept) begin
                r_last     <= i_timestamp_now;
                r_seen     <= 1'b1;
                r_fallback <= (r_period == TTA_ZERO);
            end
            if (w_load) begin
                r_sys       <= r_sys + w_passed;
                r_out_valid <= 1'b1;
                if (!r_fallback) begin
                    r_src <= r_src + w_quo;
                    r_acc <= w_rem;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; the counters above already carry the updated values.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_passed <= w_passed;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_ticks_passed      = r_passed;
    assign o_system_tick_count = r_sys;
    assign o_source_tick_count = r_src;
    assign o_leftover_counts   = r_acc;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> !o_in_ready)
        else $error("input ready while the divider is busy");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted request did not start work");

    a_fallback_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_fallback) |=> (o_ticks_passed == TTA_ONE))
        else $error("fallback request did not report one tick");

    a_fallback_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_fallback) |=> ($stable(r_src) && $stable(r_acc)))
        else $error("fallback request changed source count or accumulator");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// Testbench for the timestamp tick accumulator: random and directed timer events with a tick predictor.
module tb;
    import tta_pkg::*;

    localparam int  HALF_PERIOD = 4;
    localparam int  RESET_CYCLES = 11;
    localparam int  PHASE_ITEMS = 70;
    localparam int  CYCLE_LIMIT = 600000;

    typedef t_word t_result [4];

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_cfg_we = 1'b0;
    t_word i_cfg_data = '0;
    logic  i_in_valid = 1'b0;
    logic  o_in_ready;
    t_word i_timestamp_now = '0;
    logic  o_out_valid;
    logic  i_out_ready = 1'b0;
    t_word o_ticks_passed;
    t_word o_system_tick_count;
    t_word o_source_tick_count;
    t_word o_leftover_counts;

    // Shadow of the block state
    t_word period_shadow = '0;
    t_word last_seen_stamp = '0;
    logic  stamp_valid = 1'b0;
    t_word acc_shadow = '0;
    t_word sys_shadow = '0;
    t_word src_shadow = '0;

    t_word   stamp_q[$];
    t_result tick_results_q[$];
    int      idle_pct = 14;
    int      errors = 0;
    int      cycles = 0;
    logic    fire;
    t_result seen;
    string   field_name [4] = '{"ticks_passed", "system_tick_count",
                                "source_tick_count", "leftover_counts"};

    timestamp_tick_accumulator u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_timestamp_now     (i_timestamp_now),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_ticks_passed      (o_ticks_passed),
        .o_system_tick_count (o_system_tick_count),
        .o_source_tick_count (o_source_tick_count),
        .o_leftover_counts   (o_leftover_counts)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timestamp_tick_accumulator verification failed");
            $finish;
        end
    end

    function automatic t_word rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Credit one timer event and queue the result it should produce.
    function automatic void credit_event(t_word now);
        t_word   delta;
        t_word   passed;
        t_result res;
        if (!stamp_valid && period_shadow != '0) begin
            last_seen_stamp = now - period_shadow;
        end
        delta = now - last_seen_stamp;
        last_seen_stamp = now;
        stamp_valid = 1'b1;
        if (period_shadow != '0) begin
            acc_shadow = acc_shadow + delta;
            passed = acc_shadow / period_shadow;
            acc_shadow = acc_shadow % period_shadow;
            sys_shadow = sys_shadow + passed;
            src_shadow = src_shadow + passed;
        end else begin
            passed = TTA_ONE;
            sys_shadow = sys_shadow + TTA_ONE;
        end
        res = '{passed, sys_shadow, src_shadow, acc_shadow};
        tick_results_q.push_back(res);
    endfunction

    task automatic note_error(string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    // Driver: hold a request until accepted, then pull the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire) begin
                credit_event(i_timestamp_now);
            end
            if (!i_in_valid || fire) begin
                if (stamp_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    i_in_valid      <= 1'b1;
                    i_timestamp_now <= stamp_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen = '{o_ticks_passed, o_system_tick_count,
                         o_source_tick_count, o_leftover_counts};
                if (tick_results_q.size() == 0) begin
                    note_error($sformatf("unexpected result: ticks %h sys %h src %h left %h",
                                         seen[0], seen[1], seen[2], seen[3]));
                end else begin
                    for (int f = 0; f < 4; f++) begin
                        if (seen[f] !== tick_results_q[0][f]) begin
                            note_error($sformatf("%s: expected %h got %h", field_name[f],
                                                 tick_results_q[0][f], seen[f]));
                        end
                    end
                    void'(tick_results_q.pop_front());
                end
            end
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic wait_drained();
        while (stamp_q.size() > 0 || i_in_valid || tick_results_q.size() > 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write the period only once the block has nothing in work.
    task automatic set_period(t_word value);
        wait_drained();
        repeat (4) @(negedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        period_shadow = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly advance by whole and partial periods; sometimes jump or step back.
    function automatic t_word next_stamp(t_word prev, t_word per);
        int unsigned pick;
        t_word       step;
        pick = $urandom_range(99);
        if (pick < 8) begin
            return rand_word();
        end
        if (pick < 14) begin
            return prev - t_word'($urandom_range(5000));
        end
        if (per == '0) begin
            step = t_word'($urandom());
        end else begin
            step = per * t_word'($urandom_range(3)) + rand_word() % per;
        end
        return prev + step;
    endfunction

    initial begin
        t_word cursor;
        t_word per;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // First event seeds one period back
        set_period(t_word'(1000));
        stamp_q.push_back(t_word'(5000));
        stamp_q.push_back(t_word'(5000));
        stamp_q.push_back(t_word'(5999));
        stamp_q.push_back(t_word'(6001));
        stamp_q.push_back(t_word'(100));
        stamp_q.push_back('1);
        stamp_q.push_back('0);

        set_period(TTA_ONE);
        stamp_q.push_back(64'h8000_0000_0000_0000);
        stamp_q.push_back('1);
        stamp_q.push_back('0);

        // Largest period: drive the accumulator through its wrap
        set_period('1);
        stamp_q.push_back('0);
        stamp_q.push_back(64'hFFFF_FFFF_FFFF_FFFE);
        stamp_q.push_back(64'hFFFF_FFFF_FFFF_FFFD);
        stamp_q.push_back(t_word'(5));

        set_period('0);
        stamp_q.push_back(TTA_ONE);
        stamp_q.push_back('0);
        stamp_q.push_back('1);

        // New period applies to the whole leftover accumulator
        set_period(t_word'(3));
        stamp_q.push_back('1);
        stamp_q.push_back(t_word'(10));
        cursor = t_word'(10);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: per = TTA_ONE;
                1: per = t_word'(7);
                2: per = t_word'($urandom()) | TTA_ONE;
                3: per = '0;
                4: per = rand_word();
                5: per = 64'h8000_0000_0000_0000;
                6: per = '1;
                7: per = t_word'(16);
                default: per = t_word'($urandom_range(1, 300));
            endcase
            set_period(per);
            idle_pct = (ph == 4) ? 0 : 14;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cursor = next_stamp(cursor, per);
                stamp_q.push_back(cursor);
                // Hold off each request until the previous result is back
                if (ph == 7) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("timestamp_tick_accumulator verification clean");
        end else begin
            $display("timestamp_tick_accumulator verification failed");
        end
        $finish;
    end

endmodule
